// ===== design/keyframe_curve_interpolator_unit_macros.svh =====
// Assertion macros for the keyframe curve interpolator.
`ifndef KEYFRAME_CURVE_INTERPOLATOR_UNIT_MACROS_SVH
`define KEYFRAME_CURVE_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define KCI_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define KCI_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/kci_pkg.sv =====
// Shared types and constants of the keyframe curve interpolator.
package kci_pkg;

    localparam int TIME_W     = 16;  // unsigned Q1.15
    localparam int VALUE_W    = 32;  // signed Q16.16
    localparam int COUNT_W    = 5;
    localparam int SLOT_W     = 4;
    localparam int FRAC_W     = 17;  // Q0.16 fraction, up to 1.0
    localparam int FRAC_SHIFT = 16;
    localparam int DIV_STEPS  = 17;
    localparam int STEP_W     = 5;
    localparam int PROD_W     = FRAC_W + 1 + VALUE_W + 1;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // Request commands
    typedef enum logic [0:0] {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

    // Register word index (paddr[2])
    localparam logic [0:0] REG_KEY_COUNT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_OUTPUT
    } t_state;

    // Divider start request
    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] num;
        logic [TIME_W-1:0] den;
    } t_div_req;

    // Divider response
    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quot;
    } t_div_resp;

endpackage

// ===== design/kci_divider.sv =====
// Bit-serial restoring divider: quot = (num << 16) / den, with num <= den.
module kci_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kci_pkg::t_div_req   i_req,
    output kci_pkg::t_div_resp  o_resp
);

    logic                              r_busy;
    logic [kci_pkg::STEP_W-1:0]        r_cnt;
    logic [kci_pkg::FRAC_W-1:0]        r_rem;
    logic [kci_pkg::TIME_W-1:0]        r_den;
    logic [kci_pkg::FRAC_W-1:0]        r_quo;
    logic [kci_pkg::FRAC_W-1:0]        rem_sh;
    logic                              ge;
    logic                              last;

    // First step compares the integer part, later steps shift in a zero
    always_comb begin
        rem_sh = (r_cnt == '0) ? r_rem : {r_rem[kci_pkg::FRAC_W-2:0], 1'b0};
        ge     = rem_sh >= {1'b0, r_den};
        last   = r_cnt == kci_pkg::STEP_W'(kci_pkg::DIV_STEPS - 1);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_busy <= !last;
            r_cnt  <= r_cnt + kci_pkg::STEP_W'(1);
        end
    end

    // Datapath: one compare and subtract per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.num};
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_quo <= {r_quo[kci_pkg::FRAC_W-2:0], ge};
        end
    end

    assign o_resp.done = r_busy && last;
    assign o_resp.quot = r_quo;

endmodule

// ===== design/keyframe_curve_interpolator_unit.sv =====
// Keyframe curve interpolator: keyframe table, serial search, divider and blend.
//
// A write request stores one keyframe (time, value) in the table; the block stays idle
// and is ready again on the next cycle. A sample request scans the table one key per
// cycle through the single read port of the key memory, so it visits k keys (k up to
// key_count, clipped to MAX_KEYS), then runs the bit-serial divider for the Q0.16
// fraction, then a multiply step, a sum step and an output step. Samples at or below
// the first key or above the last key skip the divide and go from the search straight
// to the output step; an empty table goes from idle straight to the output step. The
// result sits in an output register, so a new request is taken while it waits; a
// sample that finishes while the previous result is still untaken waits for the
// output register to free. Key times must be written in ascending order; slots below
// key_count must be written before they are sampled.
`include "keyframe_curve_interpolator_unit_macros.svh"

module keyframe_curve_interpolator_unit #(
    parameter int MAX_KEYS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_command,
    input  logic [kci_pkg::SLOT_W-1:0]            i_entry_index,
    input  logic [kci_pkg::TIME_W-1:0]            i_key_time,
    input  logic signed [kci_pkg::VALUE_W-1:0]    i_key_value,
    input  logic [kci_pkg::TIME_W-1:0]            i_sample_time,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [kci_pkg::VALUE_W-1:0]    o_curve_value,
    output logic                                  o_table_empty,
    // register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [kci_pkg::ADDR_W-1:0]            paddr,
    input  logic [kci_pkg::DATA_W-1:0]            pwdata,
    output logic [kci_pkg::DATA_W-1:0]            prdata,
    output logic                                  pready
);

    localparam int IDX_W   = $clog2(MAX_KEYS);
    localparam int CNT_W   = $clog2(MAX_KEYS + 1);
    localparam int ENTRY_W = kci_pkg::TIME_W + kci_pkg::VALUE_W;

    kci_pkg::t_state                       r_state;
    kci_pkg::t_state                       n_state;

    logic [kci_pkg::COUNT_W-1:0]           r_key_count;
    logic [ENTRY_W-1:0]                    r_mem [MAX_KEYS];
    logic [ENTRY_W-1:0]                    r_rdata;
    logic [IDX_W-1:0]                      rd_addr;

    logic [kci_pkg::TIME_W-1:0]            r_sample;
    logic [CNT_W-1:0]                      r_n;
    logic [IDX_W-1:0]                      r_idx;
    logic [ENTRY_W-1:0]                    r_prev;
    logic signed [kci_pkg::VALUE_W-1:0]    r_v0;
    logic signed [kci_pkg::VALUE_W:0]      r_delta;
    logic signed [kci_pkg::PROD_W-1:0]     r_prod;
    logic signed [kci_pkg::VALUE_W-1:0]    r_res;
    logic                                  r_res_empty;
    logic                                  r_out_valid;
    logic signed [kci_pkg::VALUE_W-1:0]    r_curve;
    logic                                  r_empty;

    logic                                  cfg_write;
    logic                                  accept;
    logic                                  is_sample;
    logic                                  slot_ok;
    logic [CNT_W-1:0]                      count_clip;
    logic [CNT_W-1:0]                      idx_inc;
    logic                                  at_last;
    logic [kci_pkg::TIME_W-1:0]            ent_time;
    logic signed [kci_pkg::VALUE_W-1:0]    ent_value;
    logic [kci_pkg::TIME_W-1:0]            prev_time;
    logic signed [kci_pkg::VALUE_W-1:0]    prev_value;
    logic                                  past_key;
    logic                                  out_free;
    logic                                  out_load;
    kci_pkg::t_div_req                     div_req;
    kci_pkg::t_div_resp                    div_resp;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
        end else if (cfg_write && paddr[2] == kci_pkg::REG_KEY_COUNT) begin
            r_key_count <= pwdata[kci_pkg::COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == kci_pkg::REG_KEY_COUNT) begin
            prdata = kci_pkg::DATA_W'(r_key_count);
        end
    end

    // Request decode
    assign accept    = i_in_valid && o_in_ready;
    assign is_sample = i_command == kci_pkg::CMD_SAMPLE;
    assign slot_ok   = 32'(i_entry_index) < 32'(MAX_KEYS);
    assign count_clip = (32'(r_key_count) > 32'(MAX_KEYS)) ? CNT_W'(MAX_KEYS)
                                                           : CNT_W'(r_key_count);

    // Search view of the current and previous entries
    assign ent_time   = r_rdata[kci_pkg::VALUE_W +: kci_pkg::TIME_W];
    assign ent_value  = r_rdata[kci_pkg::VALUE_W-1:0];
    assign prev_time  = r_prev[kci_pkg::VALUE_W +: kci_pkg::TIME_W];
    assign prev_value = r_prev[kci_pkg::VALUE_W-1:0];
    assign idx_inc    = CNT_W'(r_idx) + CNT_W'(1);
    assign at_last    = idx_inc == r_n;
    assign past_key   = r_sample > ent_time;
    assign rd_addr    = (r_state == kci_pkg::ST_IDLE) ? '0 : idx_inc[IDX_W-1:0];

    // Key table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (accept && !is_sample && slot_ok) begin
            r_mem[IDX_W'(i_entry_index)] <= {i_key_time, i_key_value};
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_curve <= r_res;
            r_empty <= r_res_empty;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_curve_value = r_curve;
    assign o_table_empty = r_empty;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kci_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state and controls
    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        out_load      = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = r_sample - prev_time;
        div_req.den   = ent_time - prev_time;
        unique case (r_state)
            kci_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && is_sample) begin
                    n_state = (count_clip == '0) ? kci_pkg::ST_OUTPUT : kci_pkg::ST_SEARCH;
                end
            end
            kci_pkg::ST_SEARCH: begin
                if (past_key) begin
                    if (at_last) begin
                        n_state = kci_pkg::ST_OUTPUT;
                    end
                end else if (r_idx == '0) begin
                    n_state = kci_pkg::ST_OUTPUT;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = kci_pkg::ST_DIV;
                end
            end
            kci_pkg::ST_DIV: begin
                if (div_resp.done) begin
                    n_state = kci_pkg::ST_MUL;
                end
            end
            kci_pkg::ST_MUL: begin
                n_state = kci_pkg::ST_SUM;
            end
            kci_pkg::ST_SUM: begin
                n_state = kci_pkg::ST_OUTPUT;
            end
            kci_pkg::ST_OUTPUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = kci_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kci_pkg::ST_IDLE;
            end
        endcase
    end

    // Sample datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            kci_pkg::ST_IDLE: begin
                r_sample    <= i_sample_time;
                r_n         <= count_clip;
                r_idx       <= '0;
                r_res       <= '0;
                r_res_empty <= count_clip == '0;
            end
            kci_pkg::ST_SEARCH: begin
                if (past_key && !at_last) begin
                    r_idx  <= idx_inc[IDX_W-1:0];
                    r_prev <= r_rdata;
                end
                r_res   <= ent_value;
                r_v0    <= prev_value;
                r_delta <= $signed({ent_value[kci_pkg::VALUE_W-1], ent_value})
                         - $signed({prev_value[kci_pkg::VALUE_W-1], prev_value});
            end
            kci_pkg::ST_MUL: begin
                r_prod <= $signed({1'b0, div_resp.quot}) * r_delta;
            end
            kci_pkg::ST_SUM: begin
                // v0 + floor(frac * (v1 - v0) / 2^16)
                r_res <= r_v0 + r_prod[kci_pkg::FRAC_SHIFT +: kci_pkg::VALUE_W];
            end
            default: begin
            end
        endcase
    end

    // Fraction divider
    kci_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_resp  (div_resp)
    );

    // Checks
    `KCI_ASSERT_NEXT(a_sample_leaves_idle,
        i_in_valid && o_in_ready && i_command == kci_pkg::CMD_SAMPLE,
        r_state != kci_pkg::ST_IDLE, "sample request did not start work")
    `KCI_ASSERT_NOW(a_div_done_in_div, div_resp.done,
        r_state == kci_pkg::ST_DIV, "divider finished outside the divide state")
    `KCI_ASSERT_NEXT(a_output_loads,
        r_state == kci_pkg::ST_OUTPUT && (!o_out_valid || i_out_ready),
        o_out_valid && r_state == kci_pkg::ST_IDLE, "result not presented")
    `KCI_ASSERT_NOW(a_empty_is_zero, o_out_valid && o_table_empty,
        o_curve_value == '0, "empty table result is not zero")

endmodule

// ===== dv/tb_keyframe_curve_interpolator_unit.sv =====
// Testbench for the keyframe curve interpolator: random requests, local curve predictor, checks.
`timescale 1ns / 100ps

module tb_keyframe_curve_interpolator_unit;
    import kci_pkg::*;

    localparam int KEY_SLOTS   = 16;
    localparam int MAX_TIME    = 32768;
    localparam int RANDOM_REQS = 750;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 45;

    // One request as the driver presents it
    typedef struct {
        t_cmd                      cmd;
        logic [SLOT_W-1:0]         slot;
        logic [TIME_W-1:0]         ktime;
        logic signed [VALUE_W-1:0] kval;
        logic [TIME_W-1:0]         stime;
    } key_req_t;

    // One expected sample result
    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      empty;
    } curve_point_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic                      i_command = 1'b0;
    logic [SLOT_W-1:0]         i_entry_index = '0;
    logic [TIME_W-1:0]         i_key_time = '0;
    logic signed [VALUE_W-1:0] i_key_value = '0;
    logic [TIME_W-1:0]         i_sample_time = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [VALUE_W-1:0] o_curve_value;
    logic                      o_table_empty;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_W-1:0]         paddr = '0;
    logic [DATA_W-1:0]         pwdata = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    keyframe_curve_interpolator_unit #(
        .MAX_KEYS(KEY_SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_entry_index (i_entry_index),
        .i_key_time    (i_key_time),
        .i_key_value   (i_key_value),
        .i_sample_time (i_sample_time),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_curve_value (o_curve_value),
        .o_table_empty (o_table_empty),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predictor state: key table and count as the block should hold them
    logic [TIME_W-1:0]         key_time_tbl [KEY_SLOTS];
    logic signed [VALUE_W-1:0] key_val_tbl [KEY_SLOTS];
    logic [COUNT_W-1:0]        key_count_q = '0;

    // Key times as queued, used to aim sample times at the keys
    int                        queued_times [KEY_SLOTS];

    key_req_t                  pending_reqs [$];
    curve_point_t              samples_due [$];
    int unsigned               reqs_queued = 0;
    int unsigned               reqs_taken = 0;
    int unsigned               errors = 0;
    logic                      req_taken = 1'b0;
    logic                      idle_on = 1'b1;
    int unsigned               send_gap = 0;
    int unsigned               recv_gap = 0;
    int unsigned               hold_reqs = 0;
    int unsigned               holds_done = 0;
    int unsigned               stall_left = 0;

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Sampled curve value for time t; the table must hold at least one key
    function automatic logic signed [VALUE_W-1:0] curve_at(input logic [TIME_W-1:0] t);
        int    n;
        int    k;
        longint t0, t1, frac, v0, v1, acc;
        n = (key_count_q > KEY_SLOTS) ? KEY_SLOTS : int'(key_count_q);
        k = 0;
        while (k < n && t > key_time_tbl[k])
            k++;
        if (k == n)
            return key_val_tbl[n-1];
        if (k == 0)
            return key_val_tbl[0];
        t0   = longint'(key_time_tbl[k-1]);
        t1   = longint'(key_time_tbl[k]);
        frac = ((longint'(t) - t0) << FRAC_SHIFT) / (t1 - t0);
        v0   = key_val_tbl[k-1];
        v1   = key_val_tbl[k];
        acc  = (65536 - frac) * v0 + frac * v1;
        // arithmetic shift floors toward minus infinity
        return VALUE_W'(acc >>> FRAC_SHIFT);
    endfunction

    // Result check first, then the request taken at the same edge
    always @(posedge i_clk) begin : track_requests
        curve_point_t due;
        curve_point_t pred;
        req_taken <= i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (samples_due.size() == 0) begin
                $error("unexpected result: curve_value %0d table_empty %0b",
                       o_curve_value, o_table_empty);
                errors++;
            end else begin
                due = samples_due.pop_front();
                if (o_curve_value !== due.value) begin
                    $error("curve_value mismatch: expected %0d, actual %0d",
                           due.value, o_curve_value);
                    errors++;
                end
                if (o_table_empty !== due.empty) begin
                    $error("table_empty mismatch: expected %0b, actual %0b",
                           due.empty, o_table_empty);
                    errors++;
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            if (i_command == CMD_WRITE) begin
                key_time_tbl[i_entry_index] = i_key_time;
                key_val_tbl[i_entry_index]  = i_key_value;
            end else begin
                if (key_count_q == 0) begin
                    pred.value = '0;
                    pred.empty = 1'b1;
                end else begin
                    pred.value = curve_at(i_sample_time);
                    pred.empty = 1'b0;
                end
                samples_due = {samples_due, pred};
            end
            reqs_taken++;
        end
    end

    // Request driver with random gaps
    always @(negedge i_clk) begin : drive_requests
        key_req_t nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (send_gap != 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() != 0 && idle_on && $urandom_range(0, 5) == 0) begin
                send_gap   <= $urandom_range(0, 13);
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                nxt = pending_reqs.pop_front();
                i_command     <= nxt.cmd;
                i_entry_index <= nxt.slot;
                i_key_time    <= nxt.ktime;
                i_key_value   <= nxt.kval;
                i_sample_time <= nxt.stime;
                i_in_valid    <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: long hold on request, else random stall bursts
    always @(negedge i_clk) begin
        if (holds_done != hold_reqs) begin
            holds_done  <= holds_done + 1;
            stall_left  <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap    <= recv_gap - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            recv_gap    <= $urandom_range(0, 13);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic queue_write(input int slot, input int t, input logic [VALUE_W-1:0] v);
        key_req_t r;
        r.cmd   = CMD_WRITE;
        r.slot  = SLOT_W'(slot);
        r.ktime = TIME_W'(t);
        r.kval  = v;
        r.stime = TIME_W'($urandom);
        queued_times[slot] = t;
        pending_reqs = {pending_reqs, r};
        reqs_queued++;
    endtask

    task automatic queue_sample(input int t);
        key_req_t r;
        r.cmd   = CMD_SAMPLE;
        r.slot  = SLOT_W'($urandom);
        r.ktime = TIME_W'($urandom);
        r.kval  = $urandom;
        r.stime = TIME_W'(t);
        pending_reqs = {pending_reqs, r};
        reqs_queued++;
    endtask

    // Wait until every request is taken and every result is back, then settle
    task automatic drain();
        do @(negedge i_clk);
        while (reqs_taken != reqs_queued || samples_due.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle
    task automatic write_key_count(input int unsigned cnt);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_KEY_COUNT, 2'b00};
        pwdata  <= DATA_W'(cnt);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        key_count_q = COUNT_W'(cnt);
    endtask

    // Fill the whole table with non-decreasing times
    task automatic load_ascending_table();
        int span, step, cur;
        logic [VALUE_W-1:0] v;
        span = ($urandom_range(0, 3) == 0) ? 64 : MAX_TIME;
        step = span / 8;
        cur  = $urandom_range(0, MAX_TIME - span);
        for (int s = 0; s < KEY_SLOTS; s++) begin
            cur = cur + $urandom_range(0, step);
            if (cur > MAX_TIME)
                cur = MAX_TIME;
            case ($urandom_range(0, 5))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7FFF_FFFF;
                2:       v = $urandom_range(0, 255) - 128;
                default: v = $urandom;
            endcase
            queue_write(s, cur, v);
        end
    endtask

    function automatic int pick_sample_time();
        int t;
        int k;
        k = $urandom_range(0, KEY_SLOTS - 1);
        case ($urandom_range(0, 6))
            0:       t = 0;
            1:       t = MAX_TIME;
            2:       t = queued_times[k];
            3:       t = queued_times[k] + 1;
            4:       t = queued_times[k] - 1;
            default: t = $urandom_range(0, MAX_TIME);
        endcase
        if (t < 0)
            t = 0;
        if (t > MAX_TIME)
            t = MAX_TIME;
        return t;
    endfunction

    // Stimulus and end of run
    initial begin : run_stimulus
        int random_reqs;
        int phase;
        int cnt;
        int n_reqs;
        logic [VALUE_W-1:0] v;
        logic last_part;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, then a full ascending table with value extremes
        queue_sample(0);
        queue_sample(MAX_TIME);
        for (int s = 0; s < KEY_SLOTS; s++) begin
            if (s == 0 || s == KEY_SLOTS - 1)
                v = 32'h8000_0000;
            else if (s == 1 || s == KEY_SLOTS - 2)
                v = 32'h7FFF_FFFF;
            else
                v = $urandom;
            queue_write(s, (s == KEY_SLOTS - 1) ? MAX_TIME : s * 2184, v);
        end
        drain();

        // full table: first key, between extremes, exact key, last key
        write_key_count(KEY_SLOTS);
        queue_sample(0);
        queue_sample(1);
        queue_sample(4368);
        queue_sample(MAX_TIME - 1);
        queue_sample(MAX_TIME);
        drain();

        // short table: above the last key, and an exact middle key
        write_key_count(3);
        queue_sample(MAX_TIME);
        queue_sample(2184);
        drain();

        // count beyond the table size acts as a full table
        write_key_count(31);
        queue_sample(20000);
        drain();

        // random phases
        random_reqs = 0;
        phase = 0;
        while (random_reqs < RANDOM_REQS) begin
            phase++;
            case ($urandom_range(0, 7))
                0:       cnt = 0;
                1:       cnt = 1;
                2:       cnt = 2;
                3:       cnt = KEY_SLOTS;
                4:       cnt = $urandom_range(KEY_SLOTS + 1, 31);
                default: cnt = $urandom_range(1, KEY_SLOTS);
            endcase
            write_key_count(cnt);
            last_part = (random_reqs >= RANDOM_REQS - 100);
            idle_on = !last_part && ($urandom_range(0, 4) != 0);
            // one long receiver hold while requests keep coming
            if (phase == 3)
                hold_reqs++;
            if ($urandom_range(0, 3) != 0) begin
                load_ascending_table();
                random_reqs += KEY_SLOTS;
            end
            n_reqs = $urandom_range(20, 60);
            for (int j = 0; j < n_reqs; j++) begin
                // occasional stray write breaks the ordering
                if ($urandom_range(0, 9) == 0)
                    queue_write($urandom_range(0, KEY_SLOTS - 1), $urandom_range(0, MAX_TIME),
                                $urandom);
                else
                    queue_sample(pick_sample_time());
            end
            random_reqs += n_reqs;
            drain();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/kci_pkg.sv
design/kci_divider.sv
design/keyframe_curve_interpolator_unit.sv
dv/tb_keyframe_curve_interpolator_unit.sv
